### src/servo_write_packet_framer_defines.svh
// ---------------------------------------------------------------------------
// Servo write packet framer assertion macros
// Concurrent assertion wrappers on i_clk, removed for synthesis.
// ---------------------------------------------------------------------------
`ifndef SERVO_WRITE_PACKET_FRAMER_DEFINES_SVH
`define SERVO_WRITE_PACKET_FRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked outside reset only.
`define SWPF_ASSERT(lbl, prop) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    prop) else $error("swpf assertion failed");
// Checked at every edge, reset included.
`define SWPF_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge i_clk) \
    prop) else $error("swpf assertion failed");
`else
`define SWPF_ASSERT(lbl, prop)
`define SWPF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### src/swpf_pkg.sv
// ---------------------------------------------------------------------------
// Servo write packet framer package
// Payload types, control word format, microcode table and CRC step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swpf_pkg;

    // Request and result payloads.
    typedef struct packed {
        logic [15:0] reg_address;
        logic [31:0] data_value;
        logic [2:0]  byte_count;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_byte;

    // Byte source selected by a control word.
    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_ID,
        SRC_LEN,
        SRC_ADDR_LO,
        SRC_ADDR_HI,
        SRC_DATA,
        SRC_CRC_LO,
        SRC_CRC_HI
    } t_src;

    // One microcode word.
    typedef struct packed {
        t_src       src;
        logic [7:0] cbyte;
        logic       feed;
        logic       loop;
        logic       last;
    } t_ctrl;

    localparam logic [7:0]  HDR_FF      = 8'hFF;
    localparam logic [7:0]  HDR_FD      = 8'hFD;
    localparam logic [7:0]  WRITE_INSTR = 8'h03;
    localparam logic [7:0]  LEN_EXTRA   = 8'd5;
    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam logic [15:0] CRC_TOP     = 16'h8000;
    localparam logic [3:0]  STEP_FIRST  = 4'd0;
    localparam logic [3:0]  STEP_LAST   = 4'd12;
    localparam logic [2:0]  REG_SERVO_ID = 3'd0;

    // Microcode program, one word per packet byte position; the data word serves every data byte.
    function automatic t_ctrl ucode_word(input logic [3:0] pc);
        t_ctrl w;
        w = '{src: SRC_CONST, cbyte: 8'h00, feed: 1'b1, loop: 1'b0, last: 1'b0};
        case (pc)
            4'd0:  w.cbyte = HDR_FF;
            4'd1:  w.cbyte = HDR_FF;
            4'd2:  w.cbyte = HDR_FD;
            4'd3:  w.cbyte = 8'h00;
            4'd4:  w.src   = SRC_ID;
            4'd5:  w.src   = SRC_LEN;
            4'd6:  w.cbyte = 8'h00;
            4'd7:  w.cbyte = WRITE_INSTR;
            4'd8:  w.src   = SRC_ADDR_LO;
            4'd9:  w.src   = SRC_ADDR_HI;
            4'd10: begin
                w.src  = SRC_DATA;
                w.loop = 1'b1;
            end
            4'd11: begin
                w.src  = SRC_CRC_LO;
                w.feed = 1'b0;
            end
            4'd12: begin
                w.src  = SRC_CRC_HI;
                w.feed = 1'b0;
                w.last = 1'b1;
            end
            default: w.feed = 1'b0;
        endcase
        return w;
    endfunction

    // CRC-16, polynomial 0x8005, MSB first, one byte.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/swpf_sequencer.sv
// ---------------------------------------------------------------------------
// Servo write packet framer sequencer
// Step counter over the microcode table with a data byte loop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swpf_sequencer
    import swpf_pkg::*;
#(
    parameter int DW = 2,
    parameter int CW = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_out_free,
    input  logic [CW-1:0] i_count,
    output t_ctrl         o_ctrl,
    output logic          o_step,
    output logic          o_busy,
    output logic [DW-1:0] o_didx
);

    logic          r_busy, n_busy;
    logic [3:0]    r_pc, n_pc;
    logic [DW-1:0] r_didx, n_didx;
    t_ctrl         w_ctrl;
    logic          w_step;
    logic          w_more;
    logic [CW-1:0] w_cnt_m1;

    assign w_ctrl   = ucode_word(r_pc);
    assign w_step   = r_busy && i_out_free;
    assign w_cnt_m1 = i_count - CW'(1);
    assign w_more   = r_didx != DW'(w_cnt_m1);

    // Next step: hold the data word while bytes remain, else advance.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_didx = r_didx;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = STEP_FIRST;
            n_didx = '0;
        end else if (w_step) begin
            if (w_ctrl.loop && w_more) begin
                n_didx = r_didx + DW'(1);
            end else begin
                n_pc = r_pc + 4'd1;
            end
            if (w_ctrl.last) begin
                n_busy = 1'b0;
            end
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= STEP_FIRST;
            r_didx <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_didx <= n_didx;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_step = w_step;
    assign o_busy = r_busy;
    assign o_didx = r_didx;

endmodule

### src/swpf_datapath.sv
// ---------------------------------------------------------------------------
// Servo write packet framer datapath
// Holds the request, selects each packet byte and runs the CRC.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swpf_datapath
    import swpf_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 4,
    parameter int DW = 2,
    parameter int CW = 3
) (
    input  logic          i_clk,
    input  logic          i_start,
    input  t_in_req       i_req,
    input  logic          i_step,
    input  t_ctrl         i_ctrl,
    input  logic [DW-1:0] i_didx,
    input  logic [7:0]    i_servo_id,
    output logic [CW-1:0] o_count,
    output logic [7:0]    o_byte
);

    logic [15:0]   r_addr;
    logic [31:0]   r_data;
    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic [3:0]    w_cnt4;
    logic [31:0]   w_shift;
    logic [7:0]    w_byte;

    // Clamp the byte count to one through the maximum.
    always_comb begin
        w_cnt4 = {1'b0, i_req.byte_count};
        if (w_cnt4 == 4'd0) begin
            w_cnt4 = 4'd1;
        end else if (w_cnt4 > 4'(MAX_DATA_BYTES)) begin
            w_cnt4 = 4'(MAX_DATA_BYTES);
        end
    end

    // Data bytes past the 32-bit word shift out as zero.
    assign w_shift = r_data >> {i_didx, 3'b000};

    // Byte source select.
    always_comb begin
        case (i_ctrl.src)
            SRC_CONST:   w_byte = i_ctrl.cbyte;
            SRC_ID:      w_byte = i_servo_id;
            SRC_LEN:     w_byte = 8'(r_count) + LEN_EXTRA;
            SRC_ADDR_LO: w_byte = r_addr[7:0];
            SRC_ADDR_HI: w_byte = r_addr[15:8];
            SRC_DATA:    w_byte = w_shift[7:0];
            SRC_CRC_LO:  w_byte = r_crc[7:0];
            SRC_CRC_HI:  w_byte = r_crc[15:8];
            default:     w_byte = 8'h00;
        endcase
    end

    // Request capture and running CRC.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr  <= i_req.reg_address;
            r_data  <= i_req.data_value;
            r_count <= CW'(w_cnt4);
            r_crc   <= 16'h0000;
        end else if (i_step && i_ctrl.feed) begin
            r_crc <= crc_feed(r_crc, w_byte);
        end
    end

    assign o_count = r_count;
    assign o_byte  = w_byte;

endmodule

### src/servo_write_packet_framer.sv
// ---------------------------------------------------------------------------
// Servo write packet framer
// Turns one register-write request into a framed, CRC-protected byte stream.
// ---------------------------------------------------------------------------
// Usage:
// A request on the input channel carries address, data and byte count. The
// output channel returns the packet one byte per transfer, header first and
// the CRC high byte flagged as last; that packet is 13 to 12+MAX_DATA_BYTES
// bytes long (16 at the default).
// The servo ID is written over the APB port at address 0; it reads back.
// After input acceptance, the sequencer registers the start before the first byte steps into the output register.
// With the receiver always ready, one byte leaves per cycle: the microcode
// step counter walks the packet in clamped byte_count + 12 steps, and the
// input is free again in the cycle after the last step. The next request is
// taken while the last byte still sits in the output register.
// If the receiver stalls, the sequencer holds its step and the output byte
// holds until taken.
// Reset clears the sequencer and the output valid flag and sets the servo ID
// to 1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "servo_write_packet_framer_defines.svh"

module servo_write_packet_framer
    import swpf_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_byte   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
    localparam int CW = $clog2(MAX_DATA_BYTES + 1);

    logic [7:0]    r_id;
    logic          r_out_valid;
    t_out_byte     r_out_data;
    logic          w_start;
    logic          w_out_free;
    logic          w_step;
    logic          w_busy;
    t_ctrl         w_ctrl;
    logic [DW-1:0] w_didx;
    logic [CW-1:0] w_count;
    logic [7:0]    w_byte;
    logic          w_cfg_wr;

    assign o_in_ready = !w_busy;
    assign w_start    = i_in_valid && !w_busy;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Configuration write and read.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == REG_SERVO_ID);
    assign prdata   = (paddr == REG_SERVO_ID) ? {24'h0, r_id} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= 8'd1;
        end else if (w_cfg_wr) begin
            r_id <= pwdata[7:0];
        end
    end

    swpf_sequencer #(
        .DW(DW),
        .CW(CW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .i_count    (w_count),
        .o_ctrl     (w_ctrl),
        .o_step     (w_step),
        .o_busy     (w_busy),
        .o_didx     (w_didx)
    );

    swpf_datapath #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES),
        .DW(DW),
        .CW(CW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_start    (w_start),
        .i_req      (i_in_data),
        .i_step     (w_step),
        .i_ctrl     (w_ctrl),
        .i_didx     (w_didx),
        .i_servo_id (r_id),
        .o_count    (w_count),
        .o_byte     (w_byte)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= '{out_byte: w_byte, last: w_ctrl.last};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // An accepted request makes the block busy on the next cycle.
    `SWPF_ASSERT(a_start_busy, (i_in_valid && o_in_ready) |=> !o_in_ready)
    // The final byte step frees the input side.
    `SWPF_ASSERT(a_last_frees, (w_step && w_ctrl.last) |=> o_in_ready)
    // A waiting output byte is never overwritten.
    `SWPF_ASSERT(a_no_overwrite, (r_out_valid && !i_out_ready) |-> !w_step)
    // No request is taken while the sequencer is running.
    `SWPF_ASSERT_ALWAYS(a_no_start_busy, !(w_start && w_busy))
    // A completed configuration write lands in the servo ID register.
    `SWPF_ASSERT(a_cfg_access, w_cfg_wr |=> (r_id == $past(pwdata[7:0])))

endmodule
